// ----- design/dqpi_pkg.sv -----
// ----------------------------------------------------------------------------
// dqpi_pkg: shared types and constants of the dq current PI controller
// Word layouts of both channels, the classified job word, register indexes
// and register reset values.
// ----------------------------------------------------------------------------
package dqpi_pkg;

	// default depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	// configuration register indexes
	localparam logic [1:0] CFG_PROP_GAIN  = 2'd0;
	localparam logic [1:0] CFG_INT_GAIN   = 2'd1;
	localparam logic [1:0] CFG_INDUCTANCE = 2'd2;

	// configuration register reset values
	localparam logic [15:0] PROP_GAIN_RST  = 16'd256;
	localparam logic [15:0] INT_GAIN_RST   = 16'd0;
	localparam logic [15:0] INDUCTANCE_RST = 16'd0;

	// integrator mode codes; the unused code behaves as hold
	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_RUN   = 2'd1,
		MODE_HOLD  = 2'd2
	} mode_t;

	typedef struct packed {
		logic signed [15:0] id_reference;
		logic signed [15:0] iq_reference;
		logic signed [15:0] id_measured;
		logic signed [15:0] iq_measured;
		logic signed [15:0] vd_measured;
		logic signed [15:0] vq_measured;
		logic signed [15:0] angular_speed;
		logic        [15:0] dc_link_voltage;
		logic        [1:0]  mode;
	} in_t;

	typedef struct packed {
		logic signed [15:0] eta_d;
		logic signed [15:0] eta_q;
		logic               limited;
	} out_t;

	typedef struct packed {
		logic [15:0] prop_gain;
		logic [15:0] int_gain_times_period;
		logic [15:0] inductance;
	} cfg_t;

	// input word after classification of its mode
	typedef struct packed {
		in_t  word;
		logic clr;
		logic integ;
	} job_t;

endpackage

// ----- design/dqpi_front.sv -----
// ----------------------------------------------------------------------------
// dqpi_front: input side of the dq current PI controller
// Accepts input words, decodes the integrator mode and holds the jobs in a
// short queue until the back end takes them.
// ----------------------------------------------------------------------------
module dqpi_front import dqpi_pkg::*; #(
	parameter int unsigned Depth = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  in_t  in_word,
	output logic job_valid,
	input  logic job_pop,
	output job_t job_out
);

	localparam int unsigned PtrW = $clog2(Depth);
	localparam int unsigned CntW = $clog2(Depth + 1);

	job_t            slot_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            push;
	job_t            new_job;

	function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] ptr);
		if (ptr == PtrW'(Depth - 1)) begin
			return '0;
		end
		return ptr + PtrW'(1);
	endfunction

	assign in_stall  = (count_q == CntW'(Depth));
	assign push      = in_valid && !in_stall;
	assign job_valid = (count_q != '0);
	assign job_out   = slot_q[rd_ptr_q];

	// classify the mode once, on entry
	always_comb begin
		new_job.word  = in_word;
		new_job.clr   = (in_word.mode == MODE_CLEAR);
		new_job.integ = (in_word.mode == MODE_RUN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (job_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push, job_pop})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= new_job;
		end
	end

endmodule

// ----- design/dqpi_back.sv -----
// ----------------------------------------------------------------------------
// dqpi_back: execution side of the dq current PI controller
// Sequences the products of both axes on one multiplier per axis, divides
// each demand by the DC-link voltage two quotient bits a cycle, saturates,
// updates the integrators and holds the result word for the receiver.
// ----------------------------------------------------------------------------
module dqpi_back import dqpi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic job_valid,
	output logic job_pop,
	input  job_t job_in,
	output logic out_valid,
	input  logic out_stall,
	output out_t out_word
);

	localparam int unsigned DivIters = 9;
	localparam int unsigned CntW     = $clog2(DivIters);

	localparam logic signed [15:0] EtaMax    = 16'sh7FFF;
	localparam logic signed [15:0] EtaMin    = 16'sh8000;
	localparam logic        [17:0] QuoPosMax = 18'd32767;
	localparam logic        [17:0] QuoNegMax = 18'd32768;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_MUL0 = 8'b0000_0010,
		ST_MUL1 = 8'b0000_0100,
		ST_MUL2 = 8'b0000_1000,
		ST_MUL3 = 8'b0001_0000,
		ST_PREP = 8'b0010_0000,
		ST_DIV  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	state_t             state_q;
	logic [CntW-1:0]    cnt_q;
	job_t               job_q;
	logic               out_valid_q;
	out_t               out_q;

	logic signed [31:0] d_int_q, q_int_q;
	logic signed [31:0] wl_q;
	logic signed [35:0] d_acc_q, q_acc_q;
	logic signed [25:0] d_step_q, q_step_q;
	logic signed [49:0] d_prod_q, q_prod_q;

	logic               d_neg_q, q_neg_q;
	logic               d_zero_q, q_zero_q;
	logic               d_over_q, q_over_q;
	logic [15:0]        d_rem_q, q_rem_q;
	logic [17:0]        d_nlow_q, q_nlow_q;
	logic [17:0]        d_quo_q, q_quo_q;

	logic signed [32:0] d_ma, q_ma;
	logic signed [16:0] d_mb, q_mb;
	logic signed [49:0] d_prod, q_prod;
	logic signed [32:0] kp_ext, ki_ext;
	logic signed [16:0] err_d, err_q;
	logic [35:0]        d_mag, q_mag;
	logic [35:0]        v_lim;
	logic [17:0]        d_div, q_div;
	logic [16:0]        d_fin, q_fin;
	logic               out_free;

	// two restoring steps: {next remainder, quotient bit hi, quotient bit lo}
	function automatic logic [17:0] div2(input logic [15:0] rem, input logic [1:0] nb,
			input logic [15:0] v);
		logic [16:0] t1, t2;
		logic [15:0] r1, r2;
		logic        g1, g2;
		t1 = {rem, nb[1]};
		g1 = (t1 >= {1'b0, v});
		r1 = g1 ? 16'(t1 - {1'b0, v}) : t1[15:0];
		t2 = {r1, nb[0]};
		g2 = (t2 >= {1'b0, v});
		r2 = g2 ? 16'(t2 - {1'b0, v}) : t2[15:0];
		return {r2, g1, g2};
	endfunction

	// {limited, eta} from sign, zero, range flag and quotient magnitude
	function automatic logic [16:0] finish(input logic neg, input logic zero,
			input logic over, input logic [17:0] quo);
		logic [17:0] nq;
		nq = ~quo + 18'd1;
		if (over) begin
			if (zero) begin
				return {1'b1, 16'd0};
			end
			return {1'b1, neg ? EtaMin : EtaMax};
		end
		if (!neg) begin
			if (quo > QuoPosMax) begin
				return {1'b1, EtaMax};
			end
			return {1'b0, quo[15:0]};
		end
		if (quo > QuoNegMax) begin
			return {1'b1, EtaMin};
		end
		return {1'b0, nq[15:0]};
	endfunction

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
			input logic signed [25:0] b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		if (s[32] != s[31]) begin
			return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		return s[31:0];
	endfunction

	assign job_pop   = (state_q == ST_IDLE) && job_valid;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign kp_ext = signed'({17'd0, cfg.prop_gain});
	assign ki_ext = signed'({17'd0, cfg.int_gain_times_period});
	assign err_d  = 17'(job_q.word.id_reference) - 17'(job_q.word.id_measured);
	assign err_q  = 17'(job_q.word.iq_reference) - 17'(job_q.word.iq_measured);

	// operand selection per step
	always_comb begin
		d_ma = '0;
		d_mb = '0;
		q_ma = '0;
		q_mb = '0;
		case (state_q)
			ST_MUL0: begin
				d_ma = 33'(job_q.word.angular_speed);
				d_mb = signed'({1'b0, cfg.inductance});
				q_ma = kp_ext;
				q_mb = err_d;
			end
			ST_MUL1: begin
				d_ma = ki_ext;
				d_mb = err_d;
				q_ma = kp_ext;
				q_mb = err_q;
			end
			ST_MUL2: begin
				d_ma = 33'(wl_q);
				d_mb = 17'(job_q.word.iq_measured);
				q_ma = 33'(wl_q);
				q_mb = 17'(job_q.word.id_measured);
			end
			ST_MUL3: begin
				d_ma = ki_ext;
				d_mb = err_q;
			end
			default: begin
			end
		endcase
	end

	assign d_prod = d_ma * d_mb;
	assign q_prod = q_ma * q_mb;

	assign d_mag = d_acc_q[35] ? 36'(-d_acc_q) : 36'(d_acc_q);
	assign q_mag = q_acc_q[35] ? 36'(-q_acc_q) : 36'(q_acc_q);
	assign v_lim = {9'd0, job_q.word.dc_link_voltage, 11'd0};

	assign d_div = div2(d_rem_q, d_nlow_q[17:16], job_q.word.dc_link_voltage);
	assign q_div = div2(q_rem_q, q_nlow_q[17:16], job_q.word.dc_link_voltage);

	assign d_fin = finish(d_neg_q, d_zero_q, d_over_q, d_quo_q);
	assign q_fin = finish(q_neg_q, q_zero_q, q_over_q, q_quo_q);

	// sequencer, integrators and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			d_int_q     <= '0;
			q_int_q     <= '0;
		end else begin
			// drop the valid once taken, unless a new word replaces it
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= ST_MUL0;
						if (job_in.clr) begin
							d_int_q <= '0;
							q_int_q <= '0;
						end
					end
				end
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: state_q <= ST_PREP;
				ST_PREP: begin
					state_q <= ST_DIV;
					cnt_q   <= CntW'(DivIters - 1);
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q - CntW'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (job_q.integ) begin
							d_int_q <= sat_add(d_int_q, d_step_q);
							q_int_q <= sat_add(q_int_q, q_step_q);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		d_prod_q <= d_prod;
		q_prod_q <= q_prod;
		if (job_pop) begin
			job_q <= job_in;
		end
		case (state_q)
			ST_MUL1: begin
				wl_q    <= d_prod_q[31:0];
				d_acc_q <= 36'(d_int_q) + (36'(job_q.word.vd_measured) <<< 8)
					+ signed'(q_prod_q[35:0]);
			end
			ST_MUL2: begin
				d_step_q <= signed'(d_prod_q[33:8]);
				q_acc_q  <= 36'(q_int_q) + (36'(job_q.word.vq_measured) <<< 8)
					+ signed'(q_prod_q[35:0]);
			end
			ST_MUL3: begin
				d_acc_q <= d_acc_q - 36'(signed'(d_prod_q[49:23]));
				q_acc_q <= q_acc_q + 36'(signed'(q_prod_q[49:23]));
			end
			ST_PREP: begin
				q_step_q <= signed'(d_prod_q[33:8]);
				d_neg_q  <= d_acc_q[35];
				q_neg_q  <= q_acc_q[35];
				d_zero_q <= (d_acc_q == '0);
				q_zero_q <= (q_acc_q == '0);
				d_over_q <= !(d_mag < v_lim);
				q_over_q <= !(q_mag < v_lim);
				d_rem_q  <= d_mag[26:11];
				q_rem_q  <= q_mag[26:11];
				d_nlow_q <= {d_mag[10:0], 7'd0};
				q_nlow_q <= {q_mag[10:0], 7'd0};
				d_quo_q  <= '0;
				q_quo_q  <= '0;
			end
			ST_DIV: begin
				d_rem_q  <= d_div[17:2];
				q_rem_q  <= q_div[17:2];
				d_quo_q  <= {d_quo_q[15:0], d_div[1:0]};
				q_quo_q  <= {q_quo_q[15:0], q_div[1:0]};
				d_nlow_q <= d_nlow_q << 2;
				q_nlow_q <= q_nlow_q << 2;
			end
			ST_DONE: begin
				if (out_free) begin
					out_q.eta_d   <= signed'(d_fin[15:0]);
					out_q.eta_q   <= signed'(q_fin[15:0]);
					out_q.limited <= d_fin[16] | q_fin[16];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- design/dq_current_pi_controller_unit.sv -----
// ----------------------------------------------------------------------------
// dq_current_pi_controller_unit: dq current PI controller with decoupling
// One input word per control tick carries dq references, measured currents
// and voltages, PLL speed, DC-link voltage and the integrator mode; one
// result word carries the Q2.14 modulation indices eta_d, eta_q and the flag
// limited. Both channels use valid/stall: a word moves at a rising edge with
// valid high and stall low. The input queue holds QueueDepth words, so the
// sender keeps going while a finished result waits on a stalled receiver;
// in_stall rises only when the queue is full.
// Each word passes through the back end in order: four multiply steps on one
// multiplier per axis, a setup step, nine radix-4 divide steps by the
// DC-link voltage and a finish step. The back end works on one word at a
// time and takes the next word from the queue only once it is idle again.
// While out_stall holds the result, the back end waits in its finish step.
// Reset clears the queue, the output valid, both integrators and loads the
// register defaults (Kp = 1.0, Ki*Ts = 0, L = 0). Write registers on cfg_we
// only while no word is in flight.
// ----------------------------------------------------------------------------
module dq_current_pi_controller_unit import dqpi_pkg::*; #(
	parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         in_word,
	output logic        out_valid,
	input  logic        out_stall,
	output out_t        out_word,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t cfg_q;
	logic job_valid;
	logic job_pop;
	job_t job;

	// register file; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain             <= PROP_GAIN_RST;
			cfg_q.int_gain_times_period <= INT_GAIN_RST;
			cfg_q.inductance            <= INDUCTANCE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PROP_GAIN:  cfg_q.prop_gain             <= cfg_data;
				CFG_INT_GAIN:   cfg_q.int_gain_times_period <= cfg_data;
				CFG_INDUCTANCE: cfg_q.inductance            <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// accept and classify words, queue them for the back end
	dqpi_front #(
		.Depth(QueueDepth)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.job_valid(job_valid),
		.job_pop  (job_pop),
		.job_out  (job)
	);

	// compute the indices, advance the integrators, hold the result
	dqpi_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.job_valid(job_valid),
		.job_pop  (job_pop),
		.job_in   (job),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the dq current PI controller
// Sends dq control words through the valid/stall input channel and predicts
// each modulation index word with a local model of the PI, decoupling and
// 2/v_dc scaling path. Checks every result word in order, field by field.
// Covers directed corner words, integrator windup, output back-pressure and
// random traffic under several gain settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module testbench;
	import dqpi_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam longint ETA_MAX = 32767;
	localparam longint ETA_MIN = -32768;
	localparam longint INTEG_MAX = 64'sd2147483647;
	localparam longint INTEG_MIN = -64'sd2147483648;
	// the fourth mode code has no enum member; the block treats it as hold
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_t         in_word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_t        out_word;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_PROP_GAIN;
	logic [15:0] cfg_data = '0;

	// register copies and integrator state of the local controller model
	longint kp_gain = longint'(PROP_GAIN_RST);
	longint ki_gain = longint'(INT_GAIN_RST);
	longint ind_gain = longint'(INDUCTANCE_RST);
	longint integ_d = 0;
	longint integ_q = 0;

	out_t eta_expected[$];
	int   errors = 0;
	int   cycles = 0;

	// idle and stall percentages of the current phase
	int   send_idle_pct = 0;
	int   stall_pct = 0;
	logic hold_off_tog = 1'b0;

	// long hold-off bookkeeping of the stall driver
	int   hold_left = 0;
	logic hold_seen = 1'b0;

	dq_current_pi_controller_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Bound the run; a hang anywhere ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycles,
				eta_expected.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Local controller model
	// ------------------------------------------------------------------

	function automatic longint clamp32(input longint x);
		if (x > INTEG_MAX)
			return INTEG_MAX;
		if (x < INTEG_MIN)
			return INTEG_MIN;
		return x;
	endfunction

	// 2*u/v_dc in Q2.14, truncated toward zero; flag saturation and zero v_dc
	function automatic logic signed [15:0] scale_to_eta(input longint u, input longint vdc,
			inout logic lim);
		longint q;
		if (vdc == 0) begin
			lim = 1'b1;
			if (u > 0)
				return 16'(ETA_MAX);
			if (u < 0)
				return 16'(ETA_MIN);
			return 16'sd0;
		end
		q = (u * 128) / vdc;
		if (q > ETA_MAX) begin
			lim = 1'b1;
			return 16'(ETA_MAX);
		end
		if (q < ETA_MIN) begin
			lim = 1'b1;
			return 16'(ETA_MIN);
		end
		return 16'(q);
	endfunction

	// Form both axis demands, scale them and advance the integrators.
	function automatic out_t predict_eta(input in_t w);
		longint ed, eq, ud, uq, wl, vdc;
		logic lim;
		out_t r;
		lim = 1'b0;
		if (w.mode == MODE_CLEAR) begin
			integ_d = 0;
			integ_q = 0;
		end
		ed = longint'($signed(w.id_reference)) - longint'($signed(w.id_measured));
		eq = longint'($signed(w.iq_reference)) - longint'($signed(w.iq_measured));
		wl = longint'($signed(w.angular_speed)) * ind_gain;
		vdc = longint'(w.dc_link_voltage);
		// cross-coupling terms are floored to Q.23; arithmetic shift floors
		ud = kp_gain * ed + integ_d - ((wl * longint'($signed(w.iq_measured))) >>> 23)
			+ longint'($signed(w.vd_measured)) * 256;
		uq = kp_gain * eq + integ_q + ((wl * longint'($signed(w.id_measured))) >>> 23)
			+ longint'($signed(w.vq_measured)) * 256;
		r.eta_d = scale_to_eta(ud, vdc, lim);
		r.eta_q = scale_to_eta(uq, vdc, lim);
		r.limited = lim;
		// integrate only in run mode, after the output is formed
		if (w.mode == MODE_RUN) begin
			integ_d = clamp32(integ_d + ((ki_gain * ed) >>> 8));
			integ_q = clamp32(integ_q + ((ki_gain * eq) >>> 8));
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	// Compare each accepted result word against the oldest prediction.
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (eta_expected.size() == 0) begin
				errors++;
				$display("%0t unexpected result word eta_d %0d eta_q %0d limited %0b",
					$time, out_word.eta_d, out_word.eta_q, out_word.limited);
			end else begin
				want = eta_expected.pop_front();
				if (out_word.eta_d !== want.eta_d) begin
					errors++;
					$display("%0t eta_d expected %0d got %0d", $time, want.eta_d,
						out_word.eta_d);
				end
				if (out_word.eta_q !== want.eta_q) begin
					errors++;
					$display("%0t eta_q expected %0d got %0d", $time, want.eta_q,
						out_word.eta_q);
				end
				if (out_word.limited !== want.limited) begin
					errors++;
					$display("%0t limited expected %0b got %0b", $time, want.limited,
						out_word.limited);
				end
			end
		end
	end

	// Drive the receiver stall: random per phase, or a long hold-off when
	// the sequencer toggles its request.
	always @(posedge clk) begin
		if (hold_off_tog !== hold_seen) begin
			hold_seen = hold_off_tog;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic logic [15:0] rnd16();
		return 16'($urandom);
	endfunction

	// uniform value in [-span, span]
	function automatic logic [15:0] spread(input int unsigned span);
		return 16'($urandom_range(2 * span) - span);
	endfunction

	function automatic in_t pack_word(input int idr, input int iqr, input int idm,
			input int iqm, input int vd, input int vq, input int om, input int vdc,
			input logic [1:0] md);
		in_t w;
		w.id_reference = 16'(idr);
		w.iq_reference = 16'(iqr);
		w.id_measured = 16'(idm);
		w.iq_measured = 16'(iqm);
		w.vd_measured = 16'(vd);
		w.vq_measured = 16'(vq);
		w.angular_speed = 16'(om);
		w.dc_link_voltage = 16'(vdc);
		w.mode = md;
		return w;
	endfunction

	function automatic logic [1:0] pick_mode();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70)
			return MODE_RUN;
		if (r < 80)
			return MODE_CLEAR;
		if (r < 95)
			return MODE_HOLD;
		return MODE_UNUSED;
	endfunction

	// Tame words look like a running converter: small current errors and a
	// healthy bus. Other words are raw noise, heavy on tiny or zero v_dc.
	function automatic in_t random_word(input bit tame);
		in_t w;
		int unsigned r;
		if (tame) begin
			w.id_reference = spread(20000);
			w.iq_reference = spread(20000);
			w.id_measured = w.id_reference + spread(1500);
			w.iq_measured = w.iq_reference + spread(1500);
			w.vd_measured = spread(16000);
			w.vq_measured = spread(16000);
			w.angular_speed = spread(32767);
			w.dc_link_voltage = 16'($urandom_range(65535, 24000));
			w.mode = pick_mode();
		end else begin
			w.id_reference = rnd16();
			w.iq_reference = rnd16();
			w.id_measured = rnd16();
			w.iq_measured = rnd16();
			w.vd_measured = rnd16();
			w.vq_measured = rnd16();
			w.angular_speed = rnd16();
			r = $urandom_range(9);
			if (r == 0)
				w.dc_link_voltage = '0;
			else if (r < 3)
				w.dc_link_voltage = 16'($urandom_range(255));
			else
				w.dc_link_voltage = rnd16();
			w.mode = 2'($urandom);
		end
		return w;
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(3))
			0: return 16'd0;
			1: return 16'hFFFF;
			default: return rnd16();
		endcase
	endfunction

	// Offer one word after a random gap, hold it until accepted, then record
	// its prediction. Valid stays high on return so a following word can go
	// back to back; the gap loop or drain_results drops it.
	task automatic send_word(input in_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do
			@(posedge clk);
		while (in_stall);
		eta_expected.push_back(predict_eta(w));
	endtask

	// Drop valid and wait until every predicted word has come back, then wait
	// on the clock so the back end is surely idle.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (eta_expected.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all three registers back to back while the block is idle.
	task automatic load_gains(input logic [15:0] kp, input logic [15:0] ki,
			input logic [15:0] ind);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= CFG_PROP_GAIN;
		cfg_data <= kp;
		@(posedge clk);
		kp_gain = longint'(kp);
		cfg_index <= CFG_INT_GAIN;
		cfg_data <= ki;
		@(posedge clk);
		ki_gain = longint'(ki);
		cfg_index <= CFG_INDUCTANCE;
		cfg_data <= ind;
		@(posedge clk);
		ind_gain = longint'(ind);
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset gains (Kp = 1.0, no integral, no decoupling): field extremes,
	// every mode and the zero bus voltage cases.
	task automatic test_reset_defaults();
		send_idle_pct = 0;
		stall_pct = 0;
		send_word(pack_word(0, 0, 0, 0, 0, 0, 0, 32768, MODE_CLEAR));
		// zero bus: positive d demand, negative q demand
		send_word(pack_word(1000, -1000, 0, 0, 0, 0, 0, 0, MODE_RUN));
		// zero bus with zero demand on both axes
		send_word(pack_word(0, 0, 0, 0, 0, 0, 0, 0, MODE_HOLD));
		send_word(pack_word(32767, 32767, 32767, 32767, 32767, 32767, 32767, 65535,
			MODE_RUN));
		send_word(pack_word(-32768, -32768, -32768, -32768, -32768, -32768, -32768, 1,
			MODE_HOLD));
		send_word(pack_word(32767, -32768, -32768, 32767, 100, -100, 5000, 65535,
			MODE_UNUSED));
		send_word(pack_word(-200, 300, 100, -100, -4000, 4000, -32768, 30000, MODE_RUN));
	endtask

	// Full-scale gains on every register, then the smallest steps where
	// truncation toward zero and flooring of the decoupling term show.
	task automatic test_gain_extremes();
		load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_word(pack_word(32767, -32768, -32768, 32767, 32767, -32768, -32768, 65535,
			MODE_CLEAR));
		send_word(pack_word(32767, -32768, -32768, 32767, 32767, -32768, -32768, 65535,
			MODE_RUN));
		send_word(pack_word(10, -10, 0, 0, 0, 0, 32767, 65535, MODE_HOLD));
		send_word(pack_word(-10, 10, 0, 0, 0, 0, 32767, 65535, MODE_UNUSED));
		send_word(pack_word(0, 0, -32768, -32768, 0, 0, 32767, 65535, MODE_RUN));
		load_gains(16'd1, 16'd0, 16'd0);
		// -640/3 truncates to -213
		send_word(pack_word(-5, 5, 0, 0, 0, 0, 0, 3, MODE_CLEAR));
		load_gains(16'd0, 16'd0, 16'd0);
		// half an LSB of eta truncates to zero on both signs
		send_word(pack_word(0, 0, 0, 0, -1, 1, 0, 65535, MODE_RUN));
		load_gains(16'd0, 16'd0, 16'd1);
		// omega*L*iq of -2^-46 floors to one negative LSB of the demand
		send_word(pack_word(0, 0, 1, -1, 0, 0, 1, 1, MODE_RUN));
	endtask

	// Drive the integrators into both rails with the largest errors.
	task automatic test_integrator_windup();
		load_gains(16'd256, 16'hFFFF, 16'd0);
		send_idle_pct = 10;
		stall_pct = 10;
		send_word(pack_word(0, 0, 0, 0, 0, 0, 0, 65535, MODE_CLEAR));
		repeat (132)
			send_word(pack_word(32767, -32768, -32768, 32767, int'($signed(spread(8000))),
				int'($signed(spread(8000))), int'($signed(rnd16())),
				int'($urandom_range(65535, 1)), MODE_RUN));
		// rails must hold through hold and the unused mode code
		send_word(pack_word(0, 0, 0, 0, 0, 0, 0, 65535, MODE_HOLD));
		send_word(pack_word(-32768, 32767, 32767, -32768, 0, 0, 0, 65535, MODE_UNUSED));
		send_word(pack_word(0, 0, 0, 0, 0, 0, 0, 65535, MODE_RUN));
	endtask

	// Hold the receiver off for a long stretch while words keep coming, so
	// the input queue fills and the block raises in_stall.
	task automatic test_backpressure();
		load_gains(16'd512, 16'd300, 16'd2000);
		send_idle_pct = 0;
		stall_pct = 0;
		hold_off_tog <= ~hold_off_tog;
		repeat (16)
			send_word(random_word(1'b1));
	endtask

	// Random traffic under four idle and stall patterns, two gain settings each.
	task automatic test_random_traffic();
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 60;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 60;
				end
				default: begin
					send_idle_pct = 34;
					stall_pct = 34;
				end
			endcase
			repeat (2) begin
				load_gains(pick_gain(), pick_gain(), pick_gain());
				repeat (55)
					send_word(random_word($urandom_range(9) != 0));
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_gain_extremes();
		test_integrator_windup();
		test_backpressure();
		test_random_traffic();
		drain_results();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
